/* design/three_light_vertex_shade_assert.svh */
// Assertion macros for the three-light vertex shade block.
`ifndef THREE_LIGHT_VERTEX_SHADE_ASSERT_SVH
`define THREE_LIGHT_VERTEX_SHADE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TLVS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante completes.
`define TLVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tlvs_pkg.sv */
`default_nettype none

package tlvs_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int COMP_W     = 16;
    localparam int DIR_W      = 48;
    localparam int TINT_W     = 27;
    localparam int TCHAN_W    = 9;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W      = 2 * COMP_W;
    localparam int DOT_W       = PROD_W + 2;
    localparam int POS_W       = PROD_W;
    localparam int K_W         = 18;
    localparam int TERM_PROD_W = POS_W + K_W;
    localparam int FIX_PROD_W  = POS_W + 9;
    localparam int SH_TINT     = 2 * FRAC_BITS + 9;
    localparam int SH_FIX      = 2 * FRAC_BITS;
    localparam int SUM_W       = 10;

    localparam int PIPE_DEPTH = 4;
    localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [DIR_W-1:0]   LIGHT_ONE_RESET   = 48'h4000_F999_0000;
    localparam logic [DIR_W-1:0]   LIGHT_TWO_RESET   = 48'hC000_F999_0000;
    localparam logic [DIR_W-1:0]   LIGHT_THREE_RESET = 48'h0000_4000_0000;
    localparam logic [TCHAN_W-1:0] TINT_MAX          = 9'd256;
    localparam logic [TINT_W-1:0]  TINT_RESET        = {TINT_MAX, TINT_MAX, TINT_MAX};

    localparam logic [7:0]       CHAN_MAX         = 8'hFF;
    localparam logic [SUM_W-1:0] AMBIENT          = 10'd40;
    localparam logic [31:0]      FULL_BRIGHT_WORD = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_ONE_DIR   = 3'd0,
        REG_LIGHT_TWO_DIR   = 3'd1,
        REG_LIGHT_THREE_DIR = 3'd2,
        REG_TINT_RGB        = 3'd3,
        REG_FULL_BRIGHT     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] normal_x;
        logic signed [COMP_W-1:0] normal_y;
        logic signed [COMP_W-1:0] normal_z;
        logic                     last_normal;
    } normal_item_t;

    typedef struct packed {
        logic [31:0] colour_word;
        logic        last_colour;
    } colour_item_t;

    typedef struct packed {
        logic [DIR_W-1:0] dir_one;
        logic [DIR_W-1:0] dir_two;
        logic [DIR_W-1:0] dir_three;
        logic [K_W-1:0]   k_one_r;
        logic [K_W-1:0]   k_one_g;
        logic [K_W-1:0]   k_one_b;
        logic [K_W-1:0]   k_two_r;
        logic [K_W-1:0]   k_two_g;
        logic [K_W-1:0]   k_two_b;
        logic             full_bright;
    } cfg_t;

endpackage

`default_nettype wire

/* design/tlvs_cfg.sv */
`default_nettype none

module tlvs_cfg (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [tlvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [tlvs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tlvs_pkg::cfg_t                      cfg
);

    logic [tlvs_pkg::DIR_W-1:0]   dir_one_reg;
    logic [tlvs_pkg::DIR_W-1:0]   dir_two_reg;
    logic [tlvs_pkg::DIR_W-1:0]   dir_three_reg;
    logic [tlvs_pkg::TINT_W-1:0]  tint_reg;
    logic                         full_bright_reg;

    logic [15:0] scale_r;
    logic [15:0] scale_g;
    logic [15:0] scale_b;

    function automatic logic [15:0] scale255(logic [tlvs_pkg::TCHAN_W-1:0] raw);
        logic [tlvs_pkg::TCHAN_W-1:0] t;
        logic [16:0]                  full;
        t    = (raw > tlvs_pkg::TINT_MAX) ? tlvs_pkg::TINT_MAX : raw;
        full = {t, 8'd0} - {8'd0, t};
        return full[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_one_reg     <= tlvs_pkg::LIGHT_ONE_RESET;
            dir_two_reg     <= tlvs_pkg::LIGHT_TWO_RESET;
            dir_three_reg   <= tlvs_pkg::LIGHT_THREE_RESET;
            tint_reg        <= tlvs_pkg::TINT_RESET;
            full_bright_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlvs_pkg::REG_LIGHT_ONE_DIR:   dir_one_reg     <= cfg_data[tlvs_pkg::DIR_W-1:0];
                tlvs_pkg::REG_LIGHT_TWO_DIR:   dir_two_reg     <= cfg_data[tlvs_pkg::DIR_W-1:0];
                tlvs_pkg::REG_LIGHT_THREE_DIR: dir_three_reg   <= cfg_data[tlvs_pkg::DIR_W-1:0];
                tlvs_pkg::REG_TINT_RGB:        tint_reg        <= cfg_data[tlvs_pkg::TINT_W-1:0];
                tlvs_pkg::REG_FULL_BRIGHT:     full_bright_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    assign scale_r = scale255(tint_reg[26:18]);
    assign scale_g = scale255(tint_reg[17:9]);
    assign scale_b = scale255(tint_reg[8:0]);

    // light one weights red x4, green x2, blue x1; light two the reverse
    always_comb
    begin
        cfg.dir_one     = dir_one_reg;
        cfg.dir_two     = dir_two_reg;
        cfg.dir_three   = dir_three_reg;
        cfg.k_one_r     = {scale_r, 2'b00};
        cfg.k_one_g     = {1'b0, scale_g, 1'b0};
        cfg.k_one_b     = {2'b00, scale_b};
        cfg.k_two_r     = {2'b00, scale_r};
        cfg.k_two_g     = {1'b0, scale_g, 1'b0};
        cfg.k_two_b     = {scale_b, 2'b00};
        cfg.full_bright = full_bright_reg;
    end

endmodule

`default_nettype wire

/* design/three_light_vertex_shade.sv */
// Three-light vertex shade: one normal in, one packed colour out.
// Channels: normal_valid/normal_ready/normal_item carry one normal per transfer;
// colour_valid/colour_ready/colour_item return one colour word per normal, in order.
// Configuration: cfg_we with cfg_index and cfg_data writes one register per cycle;
// writes are to be taken only while no normal is in flight; the block does not enforce it.
// Pipeline: an accepted normal passes four registered stages (component products,
// dot sum and sign, light scaling, term clamp with channel sum and pack) before
// its colour is shown.
// Throughput: one normal per cycle unless the output stalls, set by the four-stage pipeline.
// Reset: the pipeline empties, lights and tint return to their defaults,
// full-bright mode is off.
// Stall: when colour_ready is low the output holds its colour; upstream stages keep
// filling bubbles and normal_ready falls only once all four stages are occupied.
`default_nettype none

module three_light_vertex_shade (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 normal_valid,
    output logic                                normal_ready,
    input  tlvs_pkg::normal_item_t              normal_item,
    output logic                                colour_valid,
    input  wire                                 colour_ready,
    output tlvs_pkg::colour_item_t              colour_item,
    input  wire                                 cfg_we,
    input  wire  [tlvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [tlvs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int D = tlvs_pkg::PIPE_DEPTH;

    tlvs_pkg::cfg_t cfg;

    logic [D-1:0] vld_reg;
    logic [D-1:0] adv;
    logic [D-2:0] last_reg;

    logic signed [tlvs_pkg::PROD_W-1:0]      mul_next [9];
    logic signed [tlvs_pkg::PROD_W-1:0]      mul_reg  [9];
    logic signed [tlvs_pkg::DOT_W-1:0]       dot      [3];
    logic        [tlvs_pkg::POS_W-1:0]       pos_next [3];
    logic        [tlvs_pkg::POS_W-1:0]       pos_reg  [3];
    logic        [tlvs_pkg::TERM_PROD_W-1:0] tp_next  [6];
    logic        [tlvs_pkg::TERM_PROD_W-1:0] tp_reg   [6];
    logic        [tlvs_pkg::FIX_PROD_W-1:0]  fp_next;
    logic        [tlvs_pkg::FIX_PROD_W-1:0]  fp_reg;
    logic        [7:0]                       fix_t;
    logic        [7:0]                       chan_next [3];
    tlvs_pkg::colour_item_t                  out_next;
    tlvs_pkg::colour_item_t                  out_reg;

    logic signed [tlvs_pkg::COMP_W-1:0] nrm [3];
    logic        [tlvs_pkg::DIR_W-1:0]  dirs [3];

    function automatic logic [7:0] tint_term(logic [tlvs_pkg::TERM_PROD_W-1:0] v);
        logic [tlvs_pkg::TERM_PROD_W-1:0] s;
        s = v >> tlvs_pkg::SH_TINT;
        return (|s[tlvs_pkg::TERM_PROD_W-1:8]) ? tlvs_pkg::CHAN_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] fix_term(logic [tlvs_pkg::FIX_PROD_W-1:0] v);
        logic [tlvs_pkg::FIX_PROD_W-1:0] s;
        s = v >> tlvs_pkg::SH_FIX;
        return (|s[tlvs_pkg::FIX_PROD_W-1:8]) ? tlvs_pkg::CHAN_MAX : s[7:0];
    endfunction

    function automatic logic [7:0] finish(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [tlvs_pkg::SUM_W-1:0] s;
        s = tlvs_pkg::SUM_W'(a) + tlvs_pkg::SUM_W'(b) + tlvs_pkg::SUM_W'(c)
            + tlvs_pkg::AMBIENT;
        return (s > tlvs_pkg::SUM_W'(tlvs_pkg::CHAN_MAX)) ? tlvs_pkg::CHAN_MAX : s[7:0];
    endfunction

    tlvs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // advance a stage when it is empty or the stage after it advances
    always_comb
    begin
        adv[D-1] = !vld_reg[D-1] || colour_ready;
        for (int k = D - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= normal_valid;
            end
            for (int k = 1; k < D; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1: nine component products
    always_comb
    begin
        nrm[0]  = normal_item.normal_x;
        nrm[1]  = normal_item.normal_y;
        nrm[2]  = normal_item.normal_z;
        dirs[0] = cfg.dir_one;
        dirs[1] = cfg.dir_two;
        dirs[2] = cfg.dir_three;
        for (int l = 0; l < 3; l++)
        begin
            mul_next[3*l]   = nrm[0] * $signed(dirs[l][47:32]);
            mul_next[3*l+1] = nrm[1] * $signed(dirs[l][31:16]);
            mul_next[3*l+2] = nrm[2] * $signed(dirs[l][15:0]);
        end
    end

    // stage 2: dot products, drop the non-positive ones
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            dot[l] = tlvs_pkg::DOT_W'(mul_reg[3*l]) + tlvs_pkg::DOT_W'(mul_reg[3*l+1])
                     + tlvs_pkg::DOT_W'(mul_reg[3*l+2]);
            pos_next[l] = (dot[l] > 0) ? dot[l][tlvs_pkg::POS_W-1:0] : '0;
        end
    end

    // stage 3: scale by tint weights; light three by 510
    always_comb
    begin
        tp_next[0] = tlvs_pkg::TERM_PROD_W'(pos_reg[0]) * tlvs_pkg::TERM_PROD_W'(cfg.k_one_r);
        tp_next[1] = tlvs_pkg::TERM_PROD_W'(pos_reg[0]) * tlvs_pkg::TERM_PROD_W'(cfg.k_one_g);
        tp_next[2] = tlvs_pkg::TERM_PROD_W'(pos_reg[0]) * tlvs_pkg::TERM_PROD_W'(cfg.k_one_b);
        tp_next[3] = tlvs_pkg::TERM_PROD_W'(pos_reg[1]) * tlvs_pkg::TERM_PROD_W'(cfg.k_two_r);
        tp_next[4] = tlvs_pkg::TERM_PROD_W'(pos_reg[1]) * tlvs_pkg::TERM_PROD_W'(cfg.k_two_g);
        tp_next[5] = tlvs_pkg::TERM_PROD_W'(pos_reg[1]) * tlvs_pkg::TERM_PROD_W'(cfg.k_two_b);
        fp_next    = {pos_reg[2], 9'd0} - {8'd0, pos_reg[2], 1'b0};
    end

    // stage 4: clamp terms, sum with ambient, pack, or the full-bright word when set
    always_comb
    begin
        fix_t        = fix_term(fp_reg);
        chan_next[0] = finish(tint_term(tp_reg[0]), tint_term(tp_reg[3]), fix_t);
        chan_next[1] = finish(tint_term(tp_reg[1]), tint_term(tp_reg[4]), fix_t);
        chan_next[2] = finish(tint_term(tp_reg[2]), tint_term(tp_reg[5]), fix_t);
        out_next.colour_word = cfg.full_bright ? tlvs_pkg::FULL_BRIGHT_WORD
                               : {8'd0, chan_next[0], chan_next[1], chan_next[2]};
        out_next.last_colour = last_reg[D-2];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mul_reg     <= mul_next;
            last_reg[0] <= normal_item.last_normal;
        end
        if (adv[1])
        begin
            pos_reg     <= pos_next;
            last_reg[1] <= last_reg[0];
        end
        if (adv[2])
        begin
            tp_reg      <= tp_next;
            fp_reg      <= fp_next;
            last_reg[2] <= last_reg[1];
        end
        if (adv[3])
        begin
            out_reg     <= out_next;
        end
    end

    assign normal_ready = adv[0];
    assign colour_valid = vld_reg[D-1];
    assign colour_item  = out_reg;

endmodule

`default_nettype wire

/* design/tlvs_check.sv */
`default_nettype none
`include "three_light_vertex_shade_assert.svh"

module tlvs_check (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      normal_valid,
    input wire                      normal_ready,
    input wire                      colour_valid,
    input wire                      colour_ready,
    input tlvs_pkg::colour_item_t   colour_item
);

    logic [tlvs_pkg::OCC_W-1:0] occ_reg;
    logic [tlvs_pkg::OCC_W-1:0] occ_next;

    always_comb
    begin
        occ_next = occ_reg
                   + tlvs_pkg::OCC_W'(normal_valid && normal_ready)
                   - tlvs_pkg::OCC_W'(colour_valid && colour_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `TLVS_ASSERT_NEXT(a_out_hold, clk, rst_n, colour_valid && !colour_ready, colour_valid && $stable(colour_item), "colour dropped or changed while stalled")
    `TLVS_ASSERT_NOW(a_no_phantom, clk, rst_n, colour_valid, occ_reg != '0, "colour with no normal in flight")
    `TLVS_ASSERT_NOW(a_full_stall, clk, rst_n, (occ_reg == tlvs_pkg::OCC_W'(tlvs_pkg::PIPE_DEPTH)) && !colour_ready, !normal_ready, "normal taken with pipeline full and output stalled")
    `TLVS_ASSERT_NEXT(a_latency, clk, rst_n, normal_valid && normal_ready ##1 colour_ready ##1 colour_ready ##1 colour_ready, colour_valid, "colour late with output free")

endmodule

bind three_light_vertex_shade tlvs_check u_tlvs_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .normal_valid (normal_valid),
    .normal_ready (normal_ready),
    .colour_valid (colour_valid),
    .colour_ready (colour_ready),
    .colour_item  (colour_item)
);

`default_nettype wire

/* tb/three_light_vertex_shade_tb.sv */
`default_nettype none

module three_light_vertex_shade_tb;

    localparam int LONG_HOLD       = 80;
    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS    = 1130;

    localparam logic [tlvs_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             normal_valid = 1'b0;
    logic                             normal_ready;
    tlvs_pkg::normal_item_t           normal_item = '0;
    logic                             colour_valid;
    logic                             colour_ready = 1'b0;
    tlvs_pkg::colour_item_t           colour_item;
    logic                             cfg_we = 1'b0;
    logic [tlvs_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [tlvs_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic [tlvs_pkg::DIR_W-1:0]  dir_one_q = tlvs_pkg::LIGHT_ONE_RESET;
    logic [tlvs_pkg::DIR_W-1:0]  dir_two_q = tlvs_pkg::LIGHT_TWO_RESET;
    logic [tlvs_pkg::DIR_W-1:0]  dir_three_q = tlvs_pkg::LIGHT_THREE_RESET;
    logic [tlvs_pkg::TINT_W-1:0] tint_q = tlvs_pkg::TINT_RESET;
    logic                        bright_on = 1'b0;

    tlvs_pkg::normal_item_t pending_normals[$];
    tlvs_pkg::colour_item_t expected_colours[$];
    tlvs_pkg::colour_item_t want_colour;

    int  mismatches = 0;
    int  send_wait;
    int  recv_wait;
    int  hold_left;
    int  holds_asked = 0;
    int  holds_taken;
    bit  send_gaps_on = 1'b1;
    bit  recv_stalls_on = 1'b1;

    three_light_vertex_shade dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .normal_valid (normal_valid),
        .normal_ready (normal_ready),
        .normal_item  (normal_item),
        .colour_valid (colour_valid),
        .colour_ready (colour_ready),
        .colour_item  (colour_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint light_dot(input logic [tlvs_pkg::DIR_W-1:0] dir,
                                         input tlvs_pkg::normal_item_t n);
        longint lx, ly, lz;
        lx = longint'($signed(dir[47:32]));
        ly = longint'($signed(dir[31:16]));
        lz = longint'($signed(dir[15:0]));
        return longint'($signed(n.normal_x)) * lx + longint'($signed(n.normal_y)) * ly
            + longint'($signed(n.normal_z)) * lz;
    endfunction

    function automatic longint lit_term(input longint num, input int sh);
        longint v;
        if (num <= 0)
            return 0;
        v = num >>> sh;
        if (v > 255)
            v = 255;
        return v;
    endfunction

    function automatic longint tint_level(input logic [tlvs_pkg::TCHAN_W-1:0] t);
        if (t > tlvs_pkg::TINT_MAX)
            return longint'(tlvs_pkg::TINT_MAX);
        return longint'(t);
    endfunction

    function automatic logic [7:0] clamp_chan(input longint c);
        longint v;
        v = c + longint'(tlvs_pkg::AMBIENT);
        if (v > 255)
            v = 255;
        if (v < 0)
            v = 0;
        return v[7:0];
    endfunction

    function automatic tlvs_pkg::colour_item_t shade_normal(input tlvs_pkg::normal_item_t n);
        tlvs_pkg::colour_item_t c;
        longint d1, d2, d3, tr, tg, tb, r, g, b;
        c.last_colour = n.last_normal;
        if (bright_on)
        begin
            c.colour_word = tlvs_pkg::FULL_BRIGHT_WORD;
            return c;
        end
        d1 = light_dot(dir_one_q, n);
        d2 = light_dot(dir_two_q, n);
        d3 = light_dot(dir_three_q, n);
        tr = tint_level(tint_q[26:18]);
        tg = tint_level(tint_q[17:9]);
        tb = tint_level(tint_q[8:0]);
        r = lit_term(d1 * 4 * tr * 255, tlvs_pkg::SH_TINT)
            + lit_term(d2 * 1 * tr * 255, tlvs_pkg::SH_TINT)
            + lit_term(d3 * 510, tlvs_pkg::SH_FIX);
        g = lit_term(d1 * 2 * tg * 255, tlvs_pkg::SH_TINT)
            + lit_term(d2 * 2 * tg * 255, tlvs_pkg::SH_TINT)
            + lit_term(d3 * 510, tlvs_pkg::SH_FIX);
        b = lit_term(d1 * 1 * tb * 255, tlvs_pkg::SH_TINT)
            + lit_term(d2 * 4 * tb * 255, tlvs_pkg::SH_TINT)
            + lit_term(d3 * 510, tlvs_pkg::SH_FIX);
        c.colour_word = {8'h00, clamp_chan(r), clamp_chan(g), clamp_chan(b)};
        return c;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [tlvs_pkg::CFG_DATA_W-1:0] rand_word();
        return tlvs_pkg::CFG_DATA_W'({$urandom, $urandom});
    endfunction

    function automatic logic [tlvs_pkg::COMP_W-1:0] rand_comp();
        int roll;
        logic [tlvs_pkg::COMP_W-1:0] corners [6];
        corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return tlvs_pkg::COMP_W'($urandom_range(0, 32768) - 16384);
        if (roll < 85)
            return tlvs_pkg::COMP_W'($urandom);
        return corners[$urandom_range(0, 5)];
    endfunction

    function automatic logic [tlvs_pkg::CFG_DATA_W-1:0] rand_dir();
        return {rand_comp(), rand_comp(), rand_comp()};
    endfunction

    function automatic logic [tlvs_pkg::TCHAN_W-1:0] rand_tint_chan();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return tlvs_pkg::TCHAN_W'($urandom_range(0, 256));
        if (roll < 85)
            return tlvs_pkg::TCHAN_W'($urandom_range(257, 511));
        case ($urandom_range(0, 2))
            0: return '0;
            1: return tlvs_pkg::TINT_MAX;
            default: return '1;
        endcase
    endfunction

    function automatic logic [tlvs_pkg::CFG_DATA_W-1:0] rand_tint();
        logic [tlvs_pkg::CFG_DATA_W-1:0] word;
        word = rand_word();
        word[tlvs_pkg::TINT_W-1:0] = {rand_tint_chan(), rand_tint_chan(), rand_tint_chan()};
        return word;
    endfunction

    function automatic tlvs_pkg::normal_item_t make_normal();
        tlvs_pkg::normal_item_t n;
        n.normal_x = rand_comp();
        n.normal_y = rand_comp();
        n.normal_z = rand_comp();
        n.last_normal = 1'($urandom_range(0, 1));
        return n;
    endfunction

    task automatic push_normal(input int x, input int y, input int z, input bit last);
        tlvs_pkg::normal_item_t n;
        n.normal_x = x[15:0];
        n.normal_y = y[15:0];
        n.normal_z = z[15:0];
        n.last_normal = last;
        pending_normals.push_back(n);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            pending_normals.push_back(make_normal());
    endtask

    task automatic write_reg(input logic [tlvs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tlvs_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            tlvs_pkg::REG_LIGHT_ONE_DIR:   dir_one_q = value[tlvs_pkg::DIR_W-1:0];
            tlvs_pkg::REG_LIGHT_TWO_DIR:   dir_two_q = value[tlvs_pkg::DIR_W-1:0];
            tlvs_pkg::REG_LIGHT_THREE_DIR: dir_three_q = value[tlvs_pkg::DIR_W-1:0];
            tlvs_pkg::REG_TINT_RGB:        tint_q = value[tlvs_pkg::TINT_W-1:0];
            tlvs_pkg::REG_FULL_BRIGHT:     bright_on = value[0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_normals.size() != 0 || normal_valid || expected_colours.size() != 0)
            @(negedge clk);
        repeat (tlvs_pkg::PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 3))
            0:
            begin
                send_gaps_on = 1'b0;
                recv_stalls_on = 1'b0;
            end
            1:
            begin
                send_gaps_on = 1'b1;
                recv_stalls_on = 1'b0;
            end
            2:
            begin
                send_gaps_on = 1'b0;
                recv_stalls_on = 1'b1;
            end
            default:
            begin
                send_gaps_on = 1'b1;
                recv_stalls_on = 1'b1;
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_valid <= 1'b0;
            normal_item <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (normal_valid && normal_ready)
                expected_colours.push_back(shade_normal(normal_item));
            if (!normal_valid || normal_ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait <= send_wait - 1;
                    normal_valid <= 1'b0;
                end
                else if (pending_normals.size() != 0)
                begin
                    normal_item <= pending_normals.pop_front();
                    normal_valid <= 1'b1;
                    send_wait <= send_gaps_on ? pick_gap() : 0;
                end
                else
                begin
                    normal_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_taken <= 0;
        end
        else if (holds_taken != holds_asked)
        begin
            hold_left <= LONG_HOLD;
            holds_taken <= holds_asked;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (colour_valid && colour_ready)
            begin
                if (expected_colours.size() == 0)
                begin
                    $error("colour transfer with nothing expected: colour_word %h last_colour %b",
                           colour_item.colour_word, colour_item.last_colour);
                    mismatches++;
                end
                else
                begin
                    want_colour = expected_colours.pop_front();
                    if (colour_item.colour_word !== want_colour.colour_word)
                    begin
                        $error("colour_word expected %h actual %h",
                               want_colour.colour_word, colour_item.colour_word);
                        mismatches++;
                    end
                    if (colour_item.last_colour !== want_colour.last_colour)
                    begin
                        $error("last_colour expected %b actual %b",
                               want_colour.last_colour, colour_item.last_colour);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0)
            begin
                colour_ready <= 1'b0;
            end
            else if (recv_wait != 0)
            begin
                recv_wait <= recv_wait - 1;
                colour_ready <= 1'b0;
            end
            else if (recv_stalls_on && $urandom_range(0, 99) < 20)
            begin
                recv_wait <= pick_gap();
                colour_ready <= 1'b0;
            end
            else
            begin
                colour_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #(10 * WATCHDOG_CYCLES);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [tlvs_pkg::CFG_DATA_W-1:0] word;
        int random_left;
        int count;
        int phase;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        push_normal(0, 0, 0, 1'b0);
        push_normal(32767, 32767, 32767, 1'b1);
        push_normal(-32768, -32768, -32768, 1'b0);
        push_normal(16384, 0, 0, 1'b1);
        push_normal(-16384, 0, 0, 1'b0);
        push_normal(0, 16384, 0, 1'b0);
        push_normal(0, -16384, 0, 1'b1);
        push_normal(0, 0, 16384, 1'b0);
        push_normal(0, 0, -32768, 1'b1);
        push_normal(16384, -1639, 0, 1'b0);
        push_normal(-16384, -1639, 0, 1'b1);
        push_normal(0, 32767, 0, 1'b0);
        push_normal(32767, -32768, 0, 1'b0);
        push_normal(-32768, 32767, 32767, 1'b1);
        push_normal(1, 1, 1, 1'b0);
        push_normal(-1, -1, -1, 1'b1);
        push_normal(21845, -21846, 21845, 1'b0);
        push_normal(-21846, 21845, -21846, 1'b1);
        push_normal(11585, 11585, 0, 1'b0);
        push_normal(-11585, 11585, 0, 1'b1);
        drain();

        // saturated tint and full-scale lights, with the receiver held off
        write_reg(tlvs_pkg::REG_LIGHT_ONE_DIR, 48'h7FFF_7FFF_7FFF);
        write_reg(tlvs_pkg::REG_LIGHT_TWO_DIR, 48'h7FFF_7FFF_7FFF);
        write_reg(tlvs_pkg::REG_LIGHT_THREE_DIR, 48'h7FFF_7FFF_7FFF);
        write_reg(tlvs_pkg::REG_TINT_RGB, 48'hFFFF_FFFF_FFFF);
        write_reg(tlvs_pkg::REG_FULL_BRIGHT, 48'hFFFF_FFFF_FFFE);
        end_writes();
        send_gaps_on = 1'b0;
        recv_stalls_on = 1'b1;
        holds_asked++;
        push_random(80);
        drain();

        write_reg(tlvs_pkg::REG_LIGHT_ONE_DIR, 48'h8000_8000_8000);
        write_reg(tlvs_pkg::REG_LIGHT_TWO_DIR, 48'h8000_8000_8000);
        write_reg(tlvs_pkg::REG_LIGHT_THREE_DIR, 48'h8000_8000_8000);
        write_reg(tlvs_pkg::REG_TINT_RGB, 48'h0);
        end_writes();
        send_gaps_on = 1'b1;
        push_random(80);
        drain();

        // full-bright mode, and writes to unmapped indexes must change nothing
        write_reg(tlvs_pkg::REG_FULL_BRIGHT, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SPARE_FIRST, rand_word());
        write_reg(REG_SPARE_FIRST + 3'd1, rand_word());
        write_reg(REG_SPARE_FIRST + 3'd2, rand_word());
        end_writes();
        push_random(80);
        drain();

        random_left = RANDOM_ITEMS - 240;
        phase = 0;
        while (random_left > 0)
        begin
            write_reg(tlvs_pkg::REG_LIGHT_ONE_DIR, rand_dir());
            write_reg(tlvs_pkg::REG_LIGHT_TWO_DIR, rand_dir());
            write_reg(tlvs_pkg::REG_LIGHT_THREE_DIR, rand_dir());
            write_reg(tlvs_pkg::REG_TINT_RGB, rand_tint());
            word = rand_word();
            word[0] = ($urandom_range(0, 99) < 15);
            write_reg(tlvs_pkg::REG_FULL_BRIGHT, word);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), rand_word());
            end_writes();
            pick_idling();
            if (phase % 4 == 3)
            begin
                send_gaps_on = 1'b0;
                holds_asked++;
            end
            count = $urandom_range(60, 130);
            if (count > random_left)
                count = random_left;
            push_random(count);
            random_left -= count;
            phase++;
            drain();
        end

        repeat (tlvs_pkg::PIPE_DEPTH * 4) @(negedge clk);
        if (mismatches == 0 && expected_colours.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/tlvs_pkg.sv
design/tlvs_cfg.sv
design/three_light_vertex_shade.sv
design/tlvs_check.sv
tb/three_light_vertex_shade_tb.sv
